// File: hw/rtl/nat_pkg.sv
// shared types and constants for the network node address table
package nat_pkg;

   // payload widths
   localparam int CMD_W    = 3;
   localparam int LONG_W   = 64;
   localparam int SHORT_W  = 16;
   localparam int TIME_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ADD     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REFRESH = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

   // timeout register reset value
   localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd3600000;

   // one table entry as stored in memory
   typedef struct packed {
      logic [LONG_W-1:0]  long_addr;
      logic [SHORT_W-1:0] nwk_addr;
      logic               active;
      logic [TIME_W-1:0]  seen_ms;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // memory write source selected by the controller
   typedef enum logic [1:0] {
      WR_NONE,
      WR_D,
      WR_APPEND,
      WR_REFRESH
   } wr_type;

   // controller to datapath commands
   typedef struct packed {
      logic   load;
      logic   rd_en;
      logic   rd_move;
      wr_type wr;
      logic   set_result;
      logic   dec_count;
      logic   rsp_load;
   } ctl_type;

   // datapath to controller status
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             long_hit;
      logic             short_hit;
      logic             long_short_eq;
      logic             full;
   } sts_type;

endpackage

// File: hw/rtl/nat_if.sv
// request and response channel interfaces of the node address table
interface nat_req_if import nat_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [LONG_W-1:0]   long_addr;
   logic [SHORT_W-1:0]  nwk_addr;
   logic [TIME_W-1:0]   now_ms;

   modport source (output valid, command, long_addr, nwk_addr, now_ms, input ready);
   modport sink (input valid, command, long_addr, nwk_addr, now_ms, output ready);
endinterface

interface nat_rsp_if import nat_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                available;
   logic [LONG_W-1:0]   found_long_addr;
   logic [COUNT_W-1:0]  entry_count;

   modport source (output valid, status, available, found_long_addr, entry_count,
                   input ready);
   modport sink (input valid, status, available, found_long_addr, entry_count,
                 output ready);
endinterface

// File: hw/rtl/nat_ram.sv
// generic simple dual-port ram with registered read
module nat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// File: hw/rtl/nat_datapath.sv
// datapath of the node address table: entry memory, search, compaction, results
module nat_datapath import nat_pkg::*; #(
   parameter int TABLE_DEPTH = 16,
   localparam int IDX_W = $clog2(TABLE_DEPTH),
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [TIME_W-1:0]   csr_wr_data,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [LONG_W-1:0]   req_long_addr,
   input  logic [SHORT_W-1:0]  req_nwk_addr,
   input  logic [TIME_W-1:0]   req_now_ms,
   input  ctl_type             ctl,
   input  logic [IDX_W-1:0]    rd_addr,
   output sts_type             sts,
   output logic [IDX_W-1:0]    short_idx,
   output logic [CNT_W-1:0]    count,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_available,
   output logic [LONG_W-1:0]   rsp_found_long_addr,
   output logic [COUNT_W-1:0]  rsp_entry_count
);

   logic [CMD_W-1:0]    cmd_ff;
   logic [LONG_W-1:0]   la_ff;
   logic [SHORT_W-1:0]  sa_ff;
   logic [TIME_W-1:0]   now_ff;
   logic [TIME_W-1:0]   timeout_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                long_hit_ff;
   logic [IDX_W-1:0]    long_idx_ff;
   logic [SHORT_W-1:0]  long_short_ff;
   logic                short_hit_ff;
   logic [IDX_W-1:0]    short_idx_ff;
   entry_type           short_word_ff;
   logic                cmp_en_ff;
   logic [IDX_W-1:0]    cmp_idx_ff;
   logic                mv_pend_ff;
   logic [IDX_W-1:0]    mv_dst_ff;
   logic [STATUS_W-1:0] res_status_ff;
   logic                res_avail_ff;
   logic [LONG_W-1:0]   res_found_ff;
   logic [STATUS_W-1:0] res_status_in;
   logic                res_avail_in;
   logic [LONG_W-1:0]   res_found_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_avail_ff;
   logic [LONG_W-1:0]   rsp_found_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   entry_type           rd_data;
   entry_type           wr_data;
   entry_type           new_entry;
   entry_type           refresh_entry;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [TIME_W-1:0]   age;
   logic                full;
   logic                short_cmd;

   nat_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (ctl.rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // entry images for the write port
   always_comb begin
      new_entry.long_addr   = la_ff;
      new_entry.nwk_addr    = sa_ff;
      new_entry.active      = 1'b1;
      new_entry.seen_ms     = now_ff;
      refresh_entry         = short_word_ff;
      refresh_entry.seen_ms = now_ff;
   end

   // write source: pending compaction move, else controller command
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = mv_dst_ff;
      wr_data = rd_data;
      priority if (mv_pend_ff) begin
         wr_en = 1'b1;
      end else begin
         unique case (ctl.wr)
            WR_D: begin
               wr_en   = 1'b1;
               wr_addr = long_idx_ff;
               wr_data = new_entry;
            end
            WR_APPEND: begin
               wr_en   = 1'b1;
               wr_addr = count_ff[IDX_W-1:0];
               wr_data = new_entry;
            end
            WR_REFRESH: begin
               wr_en   = 1'b1;
               wr_addr = short_idx_ff;
               wr_data = refresh_entry;
            end
            WR_NONE: begin
            end
         endcase
      end
   end

   assign full      = (count_ff == CNT_W'(TABLE_DEPTH));
   assign short_cmd = (cmd_ff == CMD_REMOVE) || (cmd_ff == CMD_QUERY) ||
                      (cmd_ff == CMD_REFRESH);
   assign age       = now_ff - short_word_ff.seen_ms;

   // result of the transaction from the search outcome
   always_comb begin
      unique case (cmd_ff)
         CMD_ADD:     res_status_in = (!long_hit_ff && full) ? ST_FULL : ST_OK;
         CMD_APPEND:  res_status_in = full ? ST_FULL : ST_OK;
         CMD_REMOVE,
         CMD_QUERY,
         CMD_REFRESH: res_status_in = short_hit_ff ? ST_OK : ST_NOT_FOUND;
         default:     res_status_in = ST_OK;
      endcase
      res_avail_in = (cmd_ff == CMD_QUERY) && short_hit_ff && short_word_ff.active &&
                     (age < timeout_ff);
      res_found_in = (short_cmd && short_hit_ff) ? short_word_ff.long_addr : '0;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         count_ff   <= '0;
         cmp_en_ff  <= 1'b0;
         mv_pend_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         cmp_en_ff  <= ctl.rd_en && !ctl.rd_move;
         mv_pend_ff <= ctl.rd_en && ctl.rd_move;
         priority if (ctl.dec_count) begin
            count_ff <= count_ff - CNT_W'(1);
         end else if (ctl.wr == WR_APPEND) begin
            count_ff <= count_ff + CNT_W'(1);
         end
      end
   end

   // transaction capture, search tracking and result registers
   always_ff @(posedge clock) begin
      cmp_idx_ff <= rd_addr;
      mv_dst_ff  <= rd_addr - IDX_W'(1);
      if (ctl.load) begin
         cmd_ff       <= req_command;
         la_ff        <= req_long_addr;
         sa_ff        <= req_nwk_addr;
         now_ff       <= req_now_ms;
         long_hit_ff  <= 1'b0;
         short_hit_ff <= 1'b0;
      end else if (cmp_en_ff) begin
         if (!long_hit_ff && (rd_data.long_addr == la_ff)) begin
            long_hit_ff   <= 1'b1;
            long_idx_ff   <= cmp_idx_ff;
            long_short_ff <= rd_data.nwk_addr;
         end
         if (!short_hit_ff && (rd_data.nwk_addr == sa_ff)) begin
            short_hit_ff  <= 1'b1;
            short_idx_ff  <= cmp_idx_ff;
            short_word_ff <= rd_data;
         end
      end
      // matched entry slides down when an earlier entry is evicted
      if (ctl.dec_count && (short_idx_ff < long_idx_ff)) begin
         long_idx_ff <= long_idx_ff - IDX_W'(1);
      end
      if (ctl.set_result) begin
         res_status_ff <= res_status_in;
         res_avail_ff  <= res_avail_in;
         res_found_ff  <= res_found_in;
      end
      if (ctl.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_avail_ff  <= res_avail_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_count_ff  <= COUNT_W'(count_ff);
      end
   end

   assign sts.cmd           = cmd_ff;
   assign sts.long_hit      = long_hit_ff;
   assign sts.short_hit     = short_hit_ff;
   assign sts.long_short_eq = (long_short_ff == sa_ff);
   assign sts.full          = full;
   assign short_idx         = short_idx_ff;
   assign count             = count_ff;

   assign rsp_status          = rsp_status_ff;
   assign rsp_available       = rsp_avail_ff;
   assign rsp_found_long_addr = rsp_found_ff;
   assign rsp_entry_count     = rsp_count_ff;

   // a compaction move never collides with a controller write
   a_no_wr_collision: assert property (@(posedge clock) disable iff (reset)
      !(mv_pend_ff && (ctl.wr != WR_NONE)))
      else $error("compaction move and controller write in the same cycle");

   // entry count stays within the table
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // removal only from a non-empty table
   a_dec_nonempty: assert property (@(posedge clock) disable iff (reset)
      ctl.dec_count |-> (count_ff != '0))
      else $error("entry removed from an empty table");

   // append never on a full table
   a_append_room: assert property (@(posedge clock) disable iff (reset)
      (ctl.wr == WR_APPEND) |-> !full)
      else $error("append on a full table");

endmodule

// File: hw/rtl/nat_controller.sv
// controller state machine of the node address table
module nat_controller import nat_pkg::*; #(
   parameter int TABLE_DEPTH = 16,
   localparam int IDX_W = $clog2(TABLE_DEPTH),
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  sts_type          sts,
   input  logic [IDX_W-1:0] short_idx,
   input  logic [CNT_W-1:0] count,
   output ctl_type          ctl,
   output logic [IDX_W-1:0] rd_addr
);

   typedef enum logic [2:0] {
      IDLE,
      SCAN,
      SCAN_END,
      DECIDE,
      SHIFT,
      SHIFT_END,
      UPD_D,
      DONE
   } state_type;

   state_type        state_ff;
   state_type        state_in;
   logic [CNT_W-1:0] idx_ff;
   logic [CNT_W-1:0] idx_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             skip_scan;

   assign skip_scan = (sts.cmd == CMD_APPEND) || (sts.cmd > CMD_REFRESH);

   // next state and command decode
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      ctl      = '0;
      ctl.wr   = WR_NONE;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               idx_in   = '0;
               state_in = SCAN;
            end
         end
         SCAN: begin
            priority if (skip_scan) begin
               state_in = DECIDE;
            end else if (idx_ff < count) begin
               ctl.rd_en = 1'b1;
               idx_in    = idx_ff + CNT_W'(1);
            end else begin
               state_in = SCAN_END;
            end
         end
         SCAN_END: begin
            state_in = DECIDE;
         end
         DECIDE: begin
            ctl.set_result = 1'b1;
            state_in       = DONE;
            unique case (sts.cmd)
               CMD_ADD: begin
                  priority if (sts.long_hit && !sts.long_short_eq && sts.short_hit) begin
                     idx_in   = CNT_W'(short_idx) + CNT_W'(1);
                     state_in = SHIFT;
                  end else if (sts.long_hit) begin
                     state_in = UPD_D;
                  end else if (!sts.full) begin
                     ctl.wr = WR_APPEND;
                  end
               end
               CMD_APPEND: begin
                  if (!sts.full) begin
                     ctl.wr = WR_APPEND;
                  end
               end
               CMD_REMOVE: begin
                  if (sts.short_hit) begin
                     idx_in   = CNT_W'(short_idx) + CNT_W'(1);
                     state_in = SHIFT;
                  end
               end
               CMD_REFRESH: begin
                  if (sts.short_hit) begin
                     ctl.wr = WR_REFRESH;
                  end
               end
               default: begin
               end
            endcase
         end
         SHIFT: begin
            // read entry idx, datapath writes it one slot lower next cycle
            if (idx_ff < count) begin
               ctl.rd_en   = 1'b1;
               ctl.rd_move = 1'b1;
               idx_in      = idx_ff + CNT_W'(1);
            end else begin
               state_in = SHIFT_END;
            end
         end
         SHIFT_END: begin
            ctl.dec_count = 1'b1;
            state_in      = (sts.cmd == CMD_ADD) ? UPD_D : DONE;
         end
         UPD_D: begin
            ctl.wr   = WR_D;
            state_in = DONE;
         end
         DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.rsp_load = 1'b1;
               state_in     = IDLE;
            end
         end
      endcase
      rsp_valid_in = ctl.rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rd_addr   = idx_ff[IDX_W-1:0];

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.rsp_load |-> !(rsp_valid_ff && !rsp_ready))
      else $error("response register overwritten while stalled");

   // compaction never reads slot zero as a source
   a_shift_src: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SHIFT) |-> (idx_ff != '0))
      else $error("compaction source index is zero");

endmodule

// File: hw/rtl/network_node_address_table_top.sv
// top level of the network node address table
//
//  channel   dir  handshake           payload
//  req_chan  in   valid/ready         command, long_addr, nwk_addr, now_ms
//  rsp_chan  out  valid/ready         status, available, found_long_addr, entry_count
//  csr       in   csr_wr_en           csr_wr_data (timeout_ms)
//
// one transaction at a time; a search reads one ram entry per cycle, then moves on to
// the decision and the result; append and unused codes skip the search
// removal or eviction adds compaction of the entries above the removed one, one ram
// read and one ram write per cycle; an add that finds its node adds an update state
// reset is synchronous: count cleared, timeout back to its default, ram not cleared
// a new request is taken while the previous result waits in the response register

module network_node_address_table_top import nat_pkg::*; #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   nat_req_if.sink            req_chan,
   nat_rsp_if.source          rsp_chan,
   input  logic               csr_wr_en,
   input  logic [TIME_W-1:0]  csr_wr_data
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   ctl_type          ctl;
   sts_type          sts;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] short_idx;
   logic [CNT_W-1:0] count;

   // sequencing
   nat_controller #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_chan.valid),
      .req_ready(req_chan.ready),
      .rsp_valid(rsp_chan.valid),
      .rsp_ready(rsp_chan.ready),
      .sts      (sts),
      .short_idx(short_idx),
      .count    (count),
      .ctl      (ctl),
      .rd_addr  (rd_addr)
   );

   // storage and arithmetic
   nat_datapath #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_command        (req_chan.command),
      .req_long_addr      (req_chan.long_addr),
      .req_nwk_addr       (req_chan.nwk_addr),
      .req_now_ms         (req_chan.now_ms),
      .ctl                (ctl),
      .rd_addr            (rd_addr),
      .sts                (sts),
      .short_idx          (short_idx),
      .count              (count),
      .rsp_status         (rsp_chan.status),
      .rsp_available      (rsp_chan.available),
      .rsp_found_long_addr(rsp_chan.found_long_addr),
      .rsp_entry_count    (rsp_chan.entry_count)
   );

endmodule
